>>> src/esbcd_pkg.sv
// Shared constants, types and helper functions for the epoch-seconds to BCD
// date/time converter. No dependencies; every other file imports this package.
`default_nettype none

package esbcd_pkg;

    // Number of register stages, from the input register to the result register.
    localparam int NUM_STG = 10;

    // Days from seconds: t / 86400 = (t >> 7) / 675, exact reciprocal over 25 bits.
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;
    localparam int          DAY_SHIFT   = 35;
    localparam logic [9:0]  DAY_ODD     = 10'd675;

    // Hours from second of day (exact for values below 86400).
    localparam logic [15:0] HOUR_RECIP    = 16'd37283;
    localparam int          HOUR_SHIFT    = 27;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;

    // Minutes from second of hour (exact for values below 3600).
    localparam logic [12:0] MIN_RECIP     = 13'd4370;
    localparam int          MIN_SHIFT     = 18;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

    // Four-year blocks of 1461 days (exact for values below 49712).
    localparam logic [15:0] QUAD_RECIP  = 16'd45934;
    localparam int          QUAD_SHIFT  = 26;
    localparam logic [10:0] QUAD_DAYS   = 11'd1461;

    // Day count of 2100-03-01: from here on a phantom Feb 29 2100 is inserted
    // so that every four-year block looks like leap + three common years.
    localparam logic [15:0] SKIP_DAY    = 16'd36584;

    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;
    localparam logic [8:0]  FEB29_DOY   = 9'd59;
    localparam logic [7:0]  CENTURY     = 8'd100;

    typedef struct packed {
        logic [NUM_STG-1:0] ld;   // per-stage register load enable
    } pipe_ctl_t;

    // First day of each month (0-based index) in a leap-year layout.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd60;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd121;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd182;
            4'd7:    r = 9'd213;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd274;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd335;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Packed BCD of a value below 100; tens by reciprocal multiply.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        ones = v - 7'({3'd0, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

>>> src/esbcd_split.sv
// Splits the seconds count into whole days and second of day (stages 1-3).
// Depends on esbcd_pkg.
`default_nettype none

module esbcd_split
    import esbcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire pipe_ctl_t   ctl,
    input  wire logic [31:0] t_in,       // stage 0 seconds count
    output logic [16:0]      sod_out,    // stage 3 second of day
    output logic [15:0]      dadj_out    // stage 3 day count, 2100 leap gap inserted
);

    logic [50:0] prod1_reg, prod1_next;
    logic [31:0] t1_reg;
    logic [15:0] days2_reg, days2_next;
    logic [31:0] t2_reg;
    logic [16:0] sod3_reg, sod3_next;
    logic [15:0] dadj3_reg, dadj3_next;
    logic [24:0] rem_w;

    always_comb begin
        prod1_next = 51'(t_in[31:7]) * 51'(DAY_RECIP);
        days2_next = prod1_reg[DAY_SHIFT +: 16];
        rem_w      = t2_reg[31:7] - 25'({9'd0, days2_reg} * 25'(DAY_ODD));
        sod3_next  = {rem_w[9:0], t2_reg[6:0]};
        dadj3_next = days2_reg + 16'(days2_reg >= SKIP_DAY);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[1]) begin
            prod1_reg <= prod1_next;
            t1_reg    <= t_in;
        end
        if (ctl.ld[2]) begin
            days2_reg <= days2_next;
            t2_reg    <= t1_reg;
        end
        if (ctl.ld[3]) begin
            sod3_reg  <= sod3_next;
            dadj3_reg <= dadj3_next;
        end
    end

    assign sod_out  = sod3_reg;
    assign dadj_out = dadj3_reg;

endmodule

`default_nettype wire

>>> src/esbcd_tod.sv
// Time of day: hours, minutes and seconds from second of day (stages 4-8).
// Depends on esbcd_pkg.
`default_nettype none

module esbcd_tod
    import esbcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire pipe_ctl_t   ctl,
    input  wire logic [16:0] sod_in,     // stage 3
    output logic [4:0]       hour_out,   // stage 8, binary
    output logic [5:0]       min_out,    // stage 8, binary
    output logic [5:0]       sec_out     // stage 8, binary (combinational off stage 8)
);

    logic [32:0] ph4_reg, ph4_next;
    logic [16:0] sod4_reg, sod5_reg;
    logic [4:0]  hour5_reg, hour5_next;
    logic [11:0] ms6_reg, ms6_next;
    logic [4:0]  hour6_reg, hour7_reg, hour8_reg;
    logic [24:0] pm7_reg, pm7_next;
    logic [11:0] ms7_reg, ms8_reg;
    logic [5:0]  min8_reg, min8_next;
    logic [16:0] ms_w;
    logic [11:0] sec_w;

    always_comb begin
        ph4_next   = 33'(sod_in) * 33'(HOUR_RECIP);
        hour5_next = ph4_reg[HOUR_SHIFT +: 5];
        ms_w       = sod5_reg - 17'({12'd0, hour5_reg} * 17'(SEC_PER_HOUR));
        ms6_next   = ms_w[11:0];
        pm7_next   = 25'(ms6_reg) * 25'(MIN_RECIP);
        min8_next  = pm7_reg[MIN_SHIFT +: 6];
        sec_w      = ms8_reg - 12'({6'd0, min8_reg} * 12'(SEC_PER_MIN));
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[4]) begin
            ph4_reg  <= ph4_next;
            sod4_reg <= sod_in;
        end
        if (ctl.ld[5]) begin
            hour5_reg <= hour5_next;
            sod5_reg  <= sod4_reg;
        end
        if (ctl.ld[6]) begin
            ms6_reg   <= ms6_next;
            hour6_reg <= hour5_reg;
        end
        if (ctl.ld[7]) begin
            pm7_reg   <= pm7_next;
            ms7_reg   <= ms6_reg;
            hour7_reg <= hour6_reg;
        end
        if (ctl.ld[8]) begin
            min8_reg  <= min8_next;
            ms8_reg   <= ms7_reg;
            hour8_reg <= hour7_reg;
        end
    end

    assign hour_out = hour8_reg;
    assign min_out  = min8_reg;
    assign sec_out  = sec_w[5:0];

endmodule

`default_nettype wire

>>> src/esbcd_date.sv
// Calendar date: year offset, month and day from the day count (stages 4-8).
// Depends on esbcd_pkg.
`default_nettype none

module esbcd_date
    import esbcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire pipe_ctl_t   ctl,
    input  wire logic [15:0] dadj_in,    // stage 3
    output logic [7:0]       year_out,   // stage 8, years since 2000
    output logic [3:0]       month_out,  // stage 8, 1-12
    output logic [4:0]       day_out     // stage 8, 1-31
);

    logic [31:0] pq4_reg, pq4_next;
    logic [15:0] dadj4_reg, dadj5_reg;
    logic [5:0]  q5_reg, q5_next, q6_reg;
    logic [10:0] r6_reg, r6_next;
    logic [7:0]  year7_reg, year7_next, year8_reg;
    logic [8:0]  doy7_reg, doy7_next;
    logic [3:0]  month8_reg, month8_next;
    logic [4:0]  day8_reg, day8_next;
    logic [15:0] r_w;
    logic [1:0]  yq;
    logic [10:0] ystart;
    logic [8:0]  doyr;
    logic [3:0]  midx;
    logic [8:0]  dom_w;

    always_comb begin
        pq4_next = 32'(dadj_in) * 32'(QUAD_RECIP);
        q5_next  = pq4_reg[QUAD_SHIFT +: 6];
        r_w      = dadj5_reg - 16'({10'd0, q5_reg} * 16'(QUAD_DAYS));
        r6_next  = r_w[10:0];

        // year inside the four-year block; the first one is the leap year
        if (r6_reg >= YEAR3_START) begin
            yq = 2'd3; ystart = YEAR3_START;
        end else if (r6_reg >= YEAR2_START) begin
            yq = 2'd2; ystart = YEAR2_START;
        end else if (r6_reg >= YEAR1_START) begin
            yq = 2'd1; ystart = YEAR1_START;
        end else begin
            yq = 2'd0; ystart = 11'd0;
        end
        doyr = 9'(r6_reg - ystart);
        // common years skip Feb 29 so one leap-layout month table serves all
        doy7_next  = (yq != 2'd0 && doyr >= FEB29_DOY) ? doyr + 9'd1 : doyr;
        year7_next = {q6_reg, yq};

        midx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (doy7_reg >= month_start(4'(i))) begin
                midx = 4'(i);
            end
        end
        month8_next = midx + 4'd1;
        dom_w       = doy7_reg - month_start(midx) + 9'd1;
        day8_next   = dom_w[4:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[4]) begin
            pq4_reg   <= pq4_next;
            dadj4_reg <= dadj_in;
        end
        if (ctl.ld[5]) begin
            q5_reg    <= q5_next;
            dadj5_reg <= dadj4_reg;
        end
        if (ctl.ld[6]) begin
            r6_reg <= r6_next;
            q6_reg <= q5_reg;
        end
        if (ctl.ld[7]) begin
            year7_reg <= year7_next;
            doy7_reg  <= doy7_next;
        end
        if (ctl.ld[8]) begin
            year8_reg  <= year7_reg;
            month8_reg <= month8_next;
            day8_reg   <= day8_next;
        end
    end

    assign year_out  = year8_reg;
    assign month_out = month8_reg;
    assign day_out   = day8_reg;

endmodule

`default_nettype wire

>>> src/epoch_seconds_to_bcd_datetime_top.sv
// Epoch-seconds to BCD calendar date/time converter, top level.
// Uses esbcd_pkg, esbcd_split, esbcd_tod and esbcd_date.
//
// Usage:
//   Slave channel (s_t*): one word is a 32-bit count of seconds since
//   2000-01-01 00:00:00. Master channel (m_t*): one word per input word with
//   second, minute, hour, day, month and two-digit year as packed BCD, plus
//   an overflow flag set for years 2100 and later (year digits wrap mod 100).
//   Pipeline: an accepted word passes through ten register stages in all,
//   from the input register to the result register on m_tdata, paced by
//   the reciprocal multipliers that each get a stage of their own.
//   Throughput: one word per cycle, sustained while m_tready is high.
//   Stall: each stage holds only while it is full and the stage after it
//   cannot move, so empty stages still fill while m_tready is low; s_tready
//   drops once every stage holds a word and m_tready is low.
//   Reset: aresetn (synchronous, active low) empties the pipeline; words in
//   flight are dropped and no result is produced for them.
`default_nettype none

module epoch_seconds_to_bcd_datetime_top
    import esbcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [6:0] second_bcd, [13:7] minute_bcd,
                                        // [19:14] hour_bcd, [25:20] day_bcd,
                                        // [30:26] month_bcd, [38:31] year_bcd,
                                        // [39] year_overflow
);

    logic [NUM_STG-1:0] vld_reg, vld_next;
    logic [NUM_STG-1:0] adv;
    pipe_ctl_t          ctl;
    logic [31:0]        t0_reg;
    logic [39:0]        out_reg, out_next;

    logic [16:0] sod;
    logic [15:0] dadj;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  year_lo;
    logic        ovf;
    logic [7:0]  sec_b, min_b, hour_b, day_b, mon_b, year_b;

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb begin
        adv[NUM_STG-1] = !vld_reg[NUM_STG-1] || m_tready;
        for (int i = NUM_STG - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        ctl.ld = adv;
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_STG; i++) begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            t0_reg <= s_tdata;
        end
        if (adv[NUM_STG-1]) begin
            out_reg <= out_next;
        end
    end

    esbcd_split u_split (
        .aclk     (aclk),
        .ctl      (ctl),
        .t_in     (t0_reg),
        .sod_out  (sod),
        .dadj_out (dadj)
    );

    esbcd_tod u_tod (
        .aclk     (aclk),
        .ctl      (ctl),
        .sod_in   (sod),
        .hour_out (hour),
        .min_out  (minute),
        .sec_out  (second)
    );

    esbcd_date u_date (
        .aclk      (aclk),
        .ctl       (ctl),
        .dadj_in   (dadj),
        .year_out  (year),
        .month_out (month),
        .day_out   (day)
    );

    always_comb begin
        ovf     = (year >= CENTURY);
        year_lo = ovf ? 7'(year - CENTURY) : year[6:0];
        sec_b   = to_bcd({1'b0, second});
        min_b   = to_bcd({1'b0, minute});
        hour_b  = to_bcd({2'b0, hour});
        day_b   = to_bcd({2'b0, day});
        mon_b   = to_bcd({3'b0, month});
        year_b  = to_bcd(year_lo);
        out_next = {ovf, year_b, mon_b[4:0], day_b[5:0], hour_b[5:0],
                    min_b[6:0], sec_b[6:0]};
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NUM_STG-1];
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire
